// File: hdl/hirf_pkg.sv
// Shared types and constants of the HEVC IDR recovery block.
package hirf_pkg;

    // Item operation codes, also used as result kinds.
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_GAP     = 2'd2;

    // Recovery machine state codes.
    localparam logic [1:0] ST_WAIT_FIRST = 2'd0;
    localparam logic [1:0] ST_RUNNING    = 2'd1;
    localparam logic [1:0] ST_WAIT_IDR   = 2'd2;

    // Wait reason codes.
    localparam logic [1:0] WR_NONE    = 2'd0;
    localparam logic [1:0] WR_TIMEOUT = 2'd1;
    localparam logic [1:0] WR_PARSE   = 2'd2;
    localparam logic [1:0] WR_INVALID = 2'd3;

    // NAL unit types of interest.
    localparam logic [5:0] NAL_VPS         = 6'd32;
    localparam logic [5:0] NAL_SPS         = 6'd33;
    localparam logic [5:0] NAL_PPS         = 6'd34;
    localparam logic [5:0] NAL_IDR_W_RADL  = 6'd19;
    localparam logic [5:0] NAL_IDR_N_LP    = 6'd20;
    localparam logic [5:0] NAL_CRA         = 6'd21;

    // Bits of the seen-flags vector.
    localparam int SEEN_VPS  = 0;
    localparam int SEEN_SPS  = 1;
    localparam int SEEN_PPS  = 2;
    localparam int SEEN_IRAP = 3;
    localparam logic [3:0] SEEN_ALL = 4'hF;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        is_idr;
        logic        parse_ok;
        logic [31:0] seq_no;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       accepted;
        logic [1:0] fsm_state;
        logic [1:0] wait_reason;
        logic       idr_valid;
        logic [5:0] key_nal_type;
        logic       gap_found;
    } t_out_item;

    // Classified command passed from the scanner to the recovery machine.
    typedef struct packed {
        logic [1:0]  kind;
        logic        is_idr;
        logic        parse_ok;
        logic        idr_valid;
        logic [5:0]  key_nal_type;
        logic [31:0] seq_no;
    } t_cmd;

endpackage

// File: hdl/hirf_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface hirf_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/hirf_front.sv
// Front end: accepts item beats, scans length-prefixed NAL units, emits commands.
module hirf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hirf_stream_if.sink       i_item,
    input  logic              i_full,
    output logic              o_push,
    output hirf_pkg::t_cmd    o_cmd
);
    import hirf_pkg::*;

    logic [1:0]  r_prefix_count, n_prefix_count;
    logic [31:0] r_length_acc, n_length_acc;
    logic [31:0] r_nal_remaining, n_nal_remaining;
    logic        r_in_payload, n_in_payload;
    logic [5:0]  r_pending_type, n_pending_type;
    logic        r_scan_stopped, n_scan_stopped;
    logic [3:0]  r_seen_flags, n_seen_flags;
    logic [5:0]  r_key_type, n_key_type;

    t_in_item    item;
    logic        accept;
    logic        is_byte;

    assign item    = i_item.payload;
    assign i_item.ready = !i_full;
    assign accept  = i_item.valid && !i_full;
    assign is_byte = (item.op == OP_BYTE);

    always_comb begin
        n_prefix_count  = r_prefix_count;
        n_length_acc    = r_length_acc;
        n_nal_remaining = r_nal_remaining;
        n_in_payload    = r_in_payload;
        n_pending_type  = r_pending_type;
        n_scan_stopped  = r_scan_stopped;
        n_seen_flags    = r_seen_flags;
        n_key_type      = r_key_type;
        if (!r_scan_stopped) begin
            if (!r_in_payload) begin
                n_length_acc = {r_length_acc[23:0], item.data_byte};
                if (r_prefix_count == 2'd3) begin
                    n_prefix_count = 2'd0;
                    if (n_length_acc == 32'd0) begin
                        n_scan_stopped = 1'b1;
                    end else begin
                        n_nal_remaining = n_length_acc;
                        n_in_payload    = 1'b1;
                    end
                end else begin
                    n_prefix_count = r_prefix_count + 2'd1;
                end
            end else begin
                if (r_nal_remaining == r_length_acc) begin
                    n_pending_type = item.data_byte[6:1];
                end
                n_nal_remaining = r_nal_remaining - 32'd1;
                if (n_nal_remaining == 32'd0) begin
                    n_in_payload = 1'b0;
                    n_length_acc = 32'd0;
                    if (n_pending_type == NAL_VPS) begin
                        n_seen_flags[SEEN_VPS] = 1'b1;
                    end else if (n_pending_type == NAL_SPS) begin
                        n_seen_flags[SEEN_SPS] = 1'b1;
                    end else if (n_pending_type == NAL_PPS) begin
                        n_seen_flags[SEEN_PPS] = 1'b1;
                    end else if (n_pending_type == NAL_IDR_W_RADL ||
                                 n_pending_type == NAL_IDR_N_LP ||
                                 n_pending_type == NAL_CRA) begin
                        n_seen_flags[SEEN_IRAP] = 1'b1;
                        n_key_type = n_pending_type;
                    end
                end
            end
        end
    end

    // Build the command; scan results count only on an AU's final beat.
    always_comb begin
        o_cmd.kind         = item.op;
        o_cmd.is_idr       = item.is_idr;
        o_cmd.parse_ok     = item.parse_ok;
        o_cmd.seq_no       = item.seq_no;
        o_cmd.idr_valid    = 1'b0;
        o_cmd.key_nal_type = 6'd0;
        if (is_byte) begin
            o_cmd.idr_valid    = (n_seen_flags == SEEN_ALL);
            o_cmd.key_nal_type = n_key_type;
        end
        o_push = 1'b0;
        case (item.op)
            OP_BYTE:    o_push = accept && item.last_byte;
            OP_TIMEOUT: o_push = accept;
            OP_GAP:     o_push = accept;
            default:    o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_count  <= 2'd0;
            r_length_acc    <= 32'd0;
            r_nal_remaining <= 32'd0;
            r_in_payload    <= 1'b0;
            r_pending_type  <= 6'd0;
            r_scan_stopped  <= 1'b0;
            r_seen_flags    <= 4'd0;
            r_key_type      <= 6'd0;
        end else if (accept && is_byte) begin
            if (item.last_byte) begin
                r_prefix_count  <= 2'd0;
                r_length_acc    <= 32'd0;
                r_nal_remaining <= 32'd0;
                r_in_payload    <= 1'b0;
                r_pending_type  <= 6'd0;
                r_scan_stopped  <= 1'b0;
                r_seen_flags    <= 4'd0;
                r_key_type      <= 6'd0;
            end else begin
                r_prefix_count  <= n_prefix_count;
                r_length_acc    <= n_length_acc;
                r_nal_remaining <= n_nal_remaining;
                r_in_payload    <= n_in_payload;
                r_pending_type  <= n_pending_type;
                r_scan_stopped  <= n_scan_stopped;
                r_seen_flags    <= n_seen_flags;
                r_key_type      <= n_key_type;
            end
        end
    end
endmodule

// File: hdl/hirf_queue.sv
// Short command queue between the scanner and the recovery machine.
module hirf_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hirf_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output hirf_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);
    import hirf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: hdl/hirf_back.sv
// Back end: recovery state machine, sequence tracking and result register.
module hirf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hirf_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    hirf_stream_if.source  o_result
);
    import hirf_pkg::*;

    typedef enum logic [1:0] {
        S_WAIT_FIRST = ST_WAIT_FIRST,
        S_RUNNING    = ST_RUNNING,
        S_WAIT_IDR   = ST_WAIT_IDR
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_reason, n_reason;
    logic [31:0] r_last_seq, n_last_seq;
    logic        r_have_last, n_have_last;
    t_out_item   r_out, n_out;
    logic        r_out_valid;
    logic        n_accepted;
    logic [31:0] diff;

    assign o_pop            = !i_empty && (!r_out_valid || o_result.ready);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;
    assign diff             = i_cmd.seq_no - (r_last_seq + 32'd1);

    always_comb begin
        n_state     = r_state;
        n_reason    = r_reason;
        n_last_seq  = r_last_seq;
        n_have_last = r_have_last;
        n_accepted  = 1'b0;
        case (i_cmd.kind)
            OP_BYTE: begin
                if (r_state == S_RUNNING) begin
                    if (i_cmd.is_idr && i_cmd.parse_ok && !i_cmd.idr_valid) begin
                        n_state  = S_WAIT_IDR;
                        n_reason = WR_INVALID;
                    end else if (!i_cmd.parse_ok) begin
                        n_state  = S_WAIT_IDR;
                        n_reason = WR_PARSE;
                    end else begin
                        n_have_last = 1'b1;
                        n_last_seq  = i_cmd.seq_no;
                        n_accepted  = 1'b1;
                    end
                end else if (i_cmd.is_idr && i_cmd.parse_ok && i_cmd.idr_valid) begin
                    n_state     = S_RUNNING;
                    n_reason    = WR_NONE;
                    n_have_last = 1'b1;
                    n_last_seq  = i_cmd.seq_no;
                    n_accepted  = 1'b1;
                end
            end
            OP_TIMEOUT: begin
                if (r_state == S_RUNNING) begin
                    n_state  = S_WAIT_IDR;
                    n_reason = WR_TIMEOUT;
                end
            end
            default: ;
        endcase

        n_out.result_kind  = i_cmd.kind;
        n_out.accepted     = n_accepted;
        n_out.fsm_state    = n_state;
        n_out.wait_reason  = n_reason;
        n_out.idr_valid    = i_cmd.idr_valid;
        n_out.key_nal_type = i_cmd.key_nal_type;
        n_out.gap_found    = (i_cmd.kind == OP_GAP) && r_have_last &&
                             (diff != 32'd0) && !diff[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WAIT_FIRST;
            r_reason    <= WR_NONE;
            r_last_seq  <= 32'd0;
            r_have_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state     <= n_state;
                r_reason    <= n_reason;
                r_last_seq  <= n_last_seq;
                r_have_last <= n_have_last;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

// File: hdl/hevc_idr_recovery_fsm.sv
// HEVC IDR recovery block: NAL scanner, command queue and recovery machine.
//
// Item beats arrive on i_item: AU bytes (op 0), AU timeout events (op 1) and
// frame sequence gap queries (op 2); op 3 beats are taken and dropped. The
// front end walks the AU's 4-byte big-endian length prefixes and NAL
// payloads one byte a cycle, marking VPS, SPS, PPS and IRAP slices only once
// a NAL's full declared length has arrived; a zero length halts the scan for
// the rest of the AU. Each AU's final byte, each timeout and each gap query
// becomes a command in a QUEUE_DEPTH-entry queue. The back end pops one
// command a cycle unless o_result stalls, steps the first-key wait /
// running / key wait machine, records the last accepted frame sequence
// number and loads a result register, which presents one beat on o_result.
// Mid-AU bytes give no result. Throughput is one beat per cycle each way
// while neither side stalls; a command is held in the queue, then in the
// result register. The scanner's 32-bit remaining-length decrement and
// compare, and the back end's 32-bit sequence subtract, set the cycle time.
// The queue absorbs output stalls: i_item.ready drops only when the queue
// is full, and bytes in the middle of an AU never fill it.
module hevc_idr_recovery_fsm #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hirf_stream_if.sink   i_item,
    hirf_stream_if.source o_result
);
    import hirf_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    // Scan and classify incoming beats.
    hirf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    // Hold commands while the result side stalls.
    hirf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Advance the recovery machine and drive the result beat.
    hirf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_result (o_result)
    );
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the HEVC IDR recovery block.
module tb_top;
    import hirf_pkg::*;

    // Op 3 has no meaning in the block; it is taken and dropped without a result.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    // A plain trailing slice, used to build non-key access units.
    localparam logic [5:0] NAL_TRAIL_R = 6'd1;
    localparam int CYCLE_LIMIT = 200000;
    // A command passes through the queue and the result register before o_result; pad the tail.
    localparam int TAIL_CYCLES = 10;

    typedef logic [7:0] au_bytes_t[$];

    logic clk;
    logic rst_n;

    hirf_stream_if #(.t_payload(t_in_item))  item_if ();
    hirf_stream_if #(.t_payload(t_out_item)) result_if ();

    hevc_idr_recovery_fsm DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // ------------------------------------------------------------------
    // Predicted block state: recovery machine and byte scanner.
    // ------------------------------------------------------------------
    logic [1:0]  mc_state    = ST_WAIT_FIRST;
    logic [1:0]  mc_reason   = WR_NONE;
    logic [31:0] mc_last_seq = '0;
    logic        mc_have_seq = 1'b0;

    logic [1:0]  sc_prefix     = '0;
    logic [31:0] sc_len        = '0;
    logic [31:0] sc_remain     = '0;
    logic        sc_in_payload = 1'b0;
    logic [5:0]  sc_pend       = '0;
    logic        sc_stopped    = 1'b0;
    logic [3:0]  sc_seen       = '0;
    logic [5:0]  sc_irap       = '0;

    // Results owed by the block, oldest first.
    t_out_item answers_due[$];

    bit          idle_on        = 1'b0;  // sender inserts idle bursts
    bit          stall_on       = 1'b0;  // receiver inserts stall bursts
    int          interleave_pct = 0;     // chance of a side item between AU bytes
    logic [31:0] seq_cursor     = 32'd1000;

    int beats_sent;
    int answers_made;
    int mismatches;
    int verdicts_seen;
    int passed_seen;
    int timeouts_seen;
    int gaps_seen;
    int cycle_count;

    function automatic bit pct(int p);
        return $urandom_range(0, 99) < p;
    endfunction

    function automatic void scan_clear();
        sc_prefix     = '0;
        sc_len        = '0;
        sc_remain     = '0;
        sc_in_payload = 1'b0;
        sc_pend       = '0;
        sc_stopped    = 1'b0;
        sc_seen       = '0;
        sc_irap       = '0;
    endfunction

    // Mark a NAL type once all of its declared bytes are in.
    function automatic void nal_commit(logic [5:0] t);
        if (t == NAL_VPS) begin
            sc_seen[SEEN_VPS] = 1'b1;
        end else if (t == NAL_SPS) begin
            sc_seen[SEEN_SPS] = 1'b1;
        end else if (t == NAL_PPS) begin
            sc_seen[SEEN_PPS] = 1'b1;
        end else if (t == NAL_IDR_W_RADL || t == NAL_IDR_N_LP || t == NAL_CRA) begin
            sc_seen[SEEN_IRAP] = 1'b1;
            sc_irap = t;
        end
    endfunction

    // Walk one AU byte: length prefix first, then payload.
    function automatic void scan_byte(logic [7:0] b);
        if (sc_stopped) return;
        if (!sc_in_payload) begin
            sc_len = {sc_len[23:0], b};
            if (sc_prefix == 2'd3) begin
                sc_prefix = '0;
                // A zero length halts the scan for the rest of the AU.
                if (sc_len == '0) begin
                    sc_stopped = 1'b1;
                end else begin
                    sc_remain     = sc_len;
                    sc_in_payload = 1'b1;
                end
            end else begin
                sc_prefix = sc_prefix + 2'd1;
            end
            return;
        end
        // The first payload byte carries the NAL header.
        if (sc_remain == sc_len) sc_pend = b[6:1];
        sc_remain = sc_remain - 32'd1;
        if (sc_remain == '0) begin
            nal_commit(sc_pend);
            sc_in_payload = 1'b0;
            sc_len        = '0;
        end
    endfunction

    function automatic void enter_wait(logic [1:0] why);
        if (mc_state == ST_WAIT_IDR) return;
        mc_state  = ST_WAIT_IDR;
        mc_reason = why;
    endfunction

    // Step the recovery machine on an AU's last byte; return the pass flag.
    function automatic logic recovery_step(logic idr, logic ok, logic valid,
                                           logic [31:0] seq);
        if (mc_state == ST_RUNNING) begin
            if (idr && ok && !valid) begin
                enter_wait(WR_INVALID);
                return 1'b0;
            end
            if (!ok) begin
                enter_wait(WR_PARSE);
                return 1'b0;
            end
            mc_have_seq = 1'b1;
            mc_last_seq = seq;
            return 1'b1;
        end
        if (!idr || !ok || !valid) return 1'b0;
        mc_state    = ST_RUNNING;
        mc_reason   = WR_NONE;
        mc_have_seq = 1'b1;
        mc_last_seq = seq;
        return 1'b1;
    endfunction

    // Advance the predicted state by one accepted item and queue its result.
    function automatic void recovery_predict(t_in_item it);
        t_out_item   r;
        logic [31:0] diff;
        r = '0;
        r.result_kind = it.op;
        case (it.op)
            OP_BYTE: begin
                scan_byte(it.data_byte);
                if (!it.last_byte) return;
                r.idr_valid    = (sc_seen == SEEN_ALL);
                r.key_nal_type = sc_irap;
                r.accepted     = recovery_step(it.is_idr, it.parse_ok, r.idr_valid,
                                               it.seq_no);
                scan_clear();
            end
            OP_TIMEOUT: begin
                if (mc_state == ST_RUNNING) enter_wait(WR_TIMEOUT);
            end
            OP_GAP: begin
                // Forward jump past last + 1, modulo 2^32, in the lower half.
                if (mc_have_seq) begin
                    diff = it.seq_no - (mc_last_seq + 32'd1);
                    r.gap_found = (diff != '0) && !diff[31];
                end
            end
            default: return;
        endcase
        r.fsm_state   = mc_state;
        r.wait_reason = mc_reason;
        answers_due.push_back(r);
        answers_made++;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Append one length-prefixed NAL; extra > 0 declares more bytes than follow.
    function automatic void add_nal(ref au_bytes_t au, input logic [5:0] t,
                                    input int plen, input int extra);
        logic [31:0] declared;
        declared = plen + extra;
        au.push_back(declared[31:24]);
        au.push_back(declared[23:16]);
        au.push_back(declared[15:8]);
        au.push_back(declared[7:0]);
        au.push_back({1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1))});
        repeat (plen - 1) au.push_back(8'($urandom));
    endfunction

    function automatic void keyframe(ref au_bytes_t au, input logic [5:0] irap);
        add_nal(au, NAL_VPS, $urandom_range(1, 3), 0);
        add_nal(au, NAL_SPS, $urandom_range(1, 3), 0);
        add_nal(au, NAL_PPS, $urandom_range(1, 3), 0);
        add_nal(au, irap, $urandom_range(1, 4), 0);
    endfunction

    function automatic logic [5:0] irap_pick();
        case ($urandom_range(0, 2))
            0:       return NAL_IDR_W_RADL;
            1:       return NAL_IDR_N_LP;
            default: return NAL_CRA;
        endcase
    endfunction

    // Mostly well-formed AUs with random content; a few carry a zero length,
    // a truncated tail or trailing bytes.
    function automatic void random_au(ref au_bytes_t au, output logic idr);
        logic [5:0] kinds[$];
        logic [5:0] tmp;
        int         j;
        int         zero_at;
        au = {};
        if (pct(45)) begin
            if (pct(90)) kinds.push_back(NAL_VPS);
            if (pct(90)) kinds.push_back(NAL_SPS);
            if (pct(90)) kinds.push_back(NAL_PPS);
            if (pct(88)) kinds.push_back(irap_pick());
            if (pct(15)) kinds.push_back(6'($urandom_range(0, 63)));
            idr = pct(85);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                if (pct(50)) kinds.push_back(NAL_TRAIL_R);
                else kinds.push_back(6'($urandom_range(0, 63)));
            end
            idr = pct(10);
        end
        if (pct(30)) begin
            for (int i = kinds.size() - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = kinds[i];
                kinds[i] = kinds[j];
                kinds[j] = tmp;
            end
        end
        zero_at = pct(8) ? $urandom_range(0, kinds.size()) : -1;
        for (int i = 0; i < kinds.size(); i++) begin
            if (i == zero_at) repeat (4) au.push_back(8'h00);
            add_nal(au, kinds[i], $urandom_range(1, 4), pct(5) ? $urandom_range(1, 3) : 0);
        end
        if (zero_at == kinds.size()) repeat (4) au.push_back(8'h00);
        if (pct(8)) begin
            repeat ($urandom_range(1, 3)) if (au.size() > 1) void'(au.pop_back());
        end
        if (pct(8)) repeat ($urandom_range(1, 3)) au.push_back(8'($urandom));
        if (au.size() == 0) au.push_back(8'($urandom));
    endfunction

    function automatic logic [31:0] next_seq();
        if (pct(80)) seq_cursor = seq_cursor + 32'd1;
        else if (pct(60)) seq_cursor = seq_cursor + $urandom_range(2, 1000);
        else seq_cursor = $urandom;
        return seq_cursor;
    endfunction

    // Query numbers clustered around the edges of the gap window.
    function automatic logic [31:0] gap_probe();
        case ($urandom_range(0, 4))
            0:       return mc_last_seq + 32'd1;
            1:       return mc_last_seq + $urandom_range(2, 5);
            2:       return mc_last_seq - $urandom_range(0, 3);
            3:       return mc_last_seq + 32'h8000_0000 - $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until the block takes the beat.
    task automatic send_item(t_in_item it);
        if (idle_on && pct(20)) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do @(posedge clk); while (!item_if.ready);
        recovery_predict(it);
        if (it.op != OP_UNUSED) beats_sent++;
    endtask

    // Timeout, gap query or undefined op; unused fields carry noise.
    task automatic send_op(logic [1:0] op, logic [31:0] seq);
        t_in_item it;
        it        = t_in_item'({$urandom, $urandom});
        it.op     = op;
        it.seq_no = seq;
        send_item(it);
    endtask

    // Send an AU byte by byte; cut forces a timeout and a gap query before
    // that byte, and interleave_pct scatters them at random.
    task automatic send_au(au_bytes_t au, logic idr, logic ok, logic [31:0] seq,
                           int cut = -1);
        t_in_item it;
        for (int i = 0; i < au.size(); i++) begin
            if (i == cut) begin
                send_op(OP_TIMEOUT, $urandom);
                send_op(OP_GAP, gap_probe());
            end else if (i > 0 && pct(interleave_pct)) begin
                send_op(pct(50) ? OP_TIMEOUT : OP_GAP, gap_probe());
            end
            it           = t_in_item'({$urandom, $urandom});
            it.op        = OP_BYTE;
            it.data_byte = au[i];
            it.last_byte = (i == au.size() - 1);
            if (it.last_byte) begin
                it.is_idr   = idr;
                it.parse_ok = ok;
                it.seq_no   = seq;
            end
            send_item(it);
        end
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic wait_drain();
        item_if.valid <= 1'b0;
        do @(posedge clk); while (answers_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before any key frame: no sequence history, nothing can pass.
    task automatic test_idle_machine();
        au_bytes_t au;
        send_op(OP_GAP, 32'd7);
        send_op(OP_TIMEOUT, $urandom);
        send_op(OP_UNUSED, $urandom);
        au = {};
        add_nal(au, NAL_TRAIL_R, 3, 0);
        send_au(au, 1'b0, 1'b1, 32'd1);
        // IRAP present but no PPS: idr_valid low, key NAL type still shown.
        au = {};
        add_nal(au, NAL_VPS, 1, 0);
        add_nal(au, NAL_SPS, 2, 0);
        add_nal(au, NAL_IDR_W_RADL, 2, 0);
        send_au(au, 1'b1, 1'b1, 32'd2);
        au = {};
        keyframe(au, NAL_IDR_W_RADL);
        send_au(au, 1'b1, 1'b0, 32'd3);
    endtask

    // First good IDR enters running; then check the gap window edges.
    task automatic test_first_idr();
        au_bytes_t au;
        au = {};
        keyframe(au, NAL_IDR_W_RADL);
        send_au(au, 1'b1, 1'b1, 32'd100);
        au = {};
        add_nal(au, NAL_TRAIL_R, 2, 0);
        send_au(au, 1'b0, 1'b1, 32'd101);
        send_op(OP_GAP, 32'd102);
        send_op(OP_GAP, 32'd103);
        send_op(OP_GAP, 32'd50);
        send_op(OP_GAP, 32'd102 + 32'h7FFF_FFFF);
        send_op(OP_GAP, 32'd102 + 32'h8000_0000);
    endtask

    // Each way into the key wait state and back out through the CRA and IDR_N_LP types.
    task automatic test_recovery_paths();
        au_bytes_t au;
        au = {};
        add_nal(au, NAL_TRAIL_R, 1, 0);
        send_au(au, 1'b1, 1'b1, 32'd150);
        send_op(OP_TIMEOUT, $urandom);
        au = {};
        keyframe(au, NAL_CRA);
        send_au(au, 1'b1, 1'b1, 32'd200);
        au = {};
        add_nal(au, NAL_TRAIL_R, 2, 0);
        send_au(au, 1'b0, 1'b0, 32'd201);
        au = {};
        keyframe(au, NAL_IDR_N_LP);
        send_au(au, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // last + 1 wraps to zero
        send_op(OP_GAP, 32'd0);
        send_op(OP_GAP, 32'd1);
        send_op(OP_TIMEOUT, $urandom);
    endtask

    // Zero length, truncated NAL, trailing bytes, side items inside an AU.
    task automatic test_scan_corners();
        au_bytes_t au;
        au = {};
        add_nal(au, NAL_VPS, 2, 0);
        add_nal(au, NAL_SPS, 1, 0);
        add_nal(au, NAL_PPS, 1, 0);
        repeat (4) au.push_back(8'h00);
        add_nal(au, NAL_IDR_W_RADL, 2, 0);
        send_au(au, 1'b1, 1'b1, 32'd300);
        au = {};
        add_nal(au, NAL_VPS, 1, 0);
        add_nal(au, NAL_SPS, 1, 0);
        add_nal(au, NAL_PPS, 1, 0);
        add_nal(au, NAL_CRA, 2, 1);
        send_au(au, 1'b1, 1'b1, 32'd301);
        au = {};
        keyframe(au, NAL_IDR_N_LP);
        repeat (3) au.push_back(8'hFF);
        send_au(au, 1'b1, 1'b1, 32'd302, 5);
        // Single-byte AUs at both data extremes.
        au = {8'hFF};
        send_au(au, 1'b1, 1'b1, 32'hFFFF_FFFF);
        au = {8'h00};
        send_au(au, 1'b0, 1'b1, 32'd0);
    endtask

    // Random traffic, idling and stalls switched on and off in stretches.
    task automatic test_random_traffic(int beat_goal, int answer_goal);
        au_bytes_t au;
        logic      idr;
        int        pick;
        while (beats_sent < beat_goal || answers_made < answer_goal) begin
            if (pct(3)) idle_on = !idle_on;
            if (pct(3)) stall_on = !stall_on;
            interleave_pct = pct(20) ? 10 : 0;
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                random_au(au, idr);
                send_au(au, idr, pct(85), next_seq());
            end else if (pick < 81) begin
                send_op(OP_TIMEOUT, $urandom);
            end else if (pick < 93) begin
                send_op(OP_GAP, gap_probe());
            end else if (pick < 96) begin
                send_op(OP_UNUSED, $urandom);
            end else begin
                // Raw noise, including huge declared lengths.
                au = {};
                repeat ($urandom_range(1, 10)) au.push_back(8'($urandom));
                send_au(au, pct(50), pct(50), $urandom);
            end
            if (pct(1)) wait_drain();
        end
        interleave_pct = 0;
    endtask

    // Let the queue run dry mid-stream, then resume.
    task automatic test_pause_for_drain();
        au_bytes_t au;
        au = {};
        keyframe(au, irap_pick());
        send_au(au, 1'b1, 1'b1, next_seq());
        send_op(OP_GAP, gap_probe());
        wait_drain();
        send_op(OP_TIMEOUT, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver, result check and watchdog
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stall bursts while stall_on, otherwise always ready.
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_on && pct(15)) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            result_if.ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every result beat with the oldest owed result.
    initial begin : result_check
        t_out_item want;
        t_out_item got;
        forever begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready) begin
                got = result_if.payload;
                if (answers_due.size() == 0) begin
                    $error("result beat with nothing owed, result_kind %0d",
                           got.result_kind);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("result_kind", want.result_kind, got.result_kind);
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("fsm_state", want.fsm_state, got.fsm_state);
                    check_field("wait_reason", want.wait_reason, got.wait_reason);
                    check_field("idr_valid", want.idr_valid, got.idr_valid);
                    check_field("key_nal_type", want.key_nal_type, got.key_nal_type);
                    check_field("gap_found", want.gap_found, got.gap_found);
                    case (want.result_kind)
                        OP_BYTE: begin
                            verdicts_seen++;
                            if (want.accepted) passed_seen++;
                        end
                        OP_TIMEOUT: timeouts_seen++;
                        default:    gaps_seen++;
                    endcase
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n           <= 1'b0;
        item_if.valid   <= 1'b0;
        item_if.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_machine();
        test_first_idr();
        test_recovery_paths();
        test_scan_corners();

        idle_on  = 1'b1;
        stall_on = 1'b1;
        test_random_traffic(beats_sent + 300, 0);
        test_pause_for_drain();
        test_random_traffic(beats_sent + 300, 60);

        // Final stretch runs flat out on both sides.
        idle_on  = 1'b0;
        stall_on = 1'b0;
        test_random_traffic(beats_sent + 80, 0);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d item beats; checked %0d AU verdicts (%0d passed),",
                 beats_sent, verdicts_seen, passed_seen);
        $display("  %0d timeout acks and %0d gap answers; %0d mismatches",
                 timeouts_seen, gaps_seen, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
